// File: src/gfd_pkg.sv
package gfd_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [23:0] RESET_GAIN = 24'd91345;
    localparam logic [7:0]  CHECK_MASK = 8'h7F;

    // Frame byte positions
    localparam logic [3:0] IDX_RATE_B0    = 4'd0;
    localparam logic [3:0] IDX_RATE_B1    = 4'd1;
    localparam logic [3:0] IDX_RATE_B2    = 4'd2;
    localparam logic [3:0] IDX_RATE_B3    = 4'd3;
    localparam logic [3:0] IDX_RATE_B4    = 4'd4;
    localparam logic [3:0] IDX_RATE_CHECK = 4'd5;
    localparam logic [3:0] IDX_TEMP_LO    = 4'd6;
    localparam logic [3:0] IDX_TEMP_HI    = 4'd7;
    localparam logic [3:0] IDX_TEMP_CHECK = 4'd8;
    localparam logic [3:0] IDX_IDLE       = 4'd9;

    typedef struct packed {
        logic [31:0] rate_raw;
        logic [13:0] temperature;
        logic        rate_ok;
        logic        temp_ok;
    } frame_t;

    typedef struct packed {
        logic [31:0] rate_raw;
        logic [39:0] rate_scaled;
        logic [13:0] temperature;
        logic        rate_ok;
        logic        temp_ok;
    } result_t;

endpackage

// File: src/gyro_frame_decoder.sv
// Gyro serial frame decoder.
//
// Input channel (push/full): one frame byte per transaction, rx_byte plus
// frame_start, which marks byte 0 and always restarts a frame. Bytes seen
// outside a frame are dropped. The ninth byte of a frame produces one result.
// Result channel (empty/pop): queue-style; the oldest result sits on the
// ports while empty is low and leaves on pop.
// Config channel (cfg_valid/cfg_ready): writes rate_gain, 24-bit unsigned;
// cfg_ready is always high. Write only while the block is idle.
//
// Throughput: one byte per cycle while full is low. A result shows (empty
// low) once byte 8 has passed the frame queue write, the multiply stage and
// the output queue write; the multiply stage waits for output queue room.
// full rises only when both frame queue entries are occupied,
// i.e. when the receiver has left results waiting; it then blocks all bytes.
// Reset: frame tracking goes idle (waits for frame_start), both queues empty,
// rate_gain back to 91345.
module gyro_frame_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    // byte input
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    // config
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    // results
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] rate_raw,
    output logic signed [39:0] rate_scaled,
    output logic [13:0]        temperature,
    output logic               rate_ok,
    output logic               temp_ok
);

    logic [23:0]      rate_gain_reg, rate_gain_next;
    logic             byte_accept;
    logic             frame_valid;
    gfd_pkg::frame_t  frame_data;
    logic             head_valid;
    gfd_pkg::frame_t  head_data;
    logic             head_pop;
    gfd_pkg::result_t result;

    assign cfg_ready      = 1'b1;
    assign rate_gain_next = (cfg_valid && cfg_ready) ? cfg_data : rate_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_gain_reg <= gfd_pkg::RESET_GAIN;
        end
        else
        begin
            rate_gain_reg <= rate_gain_next;
        end
    end

    // a byte may complete a frame at any time, so a full frame queue stalls input
    assign byte_accept = push && !full;

    gfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .frame_valid (frame_valid),
        .frame_data  (frame_data)
    );

    gfd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (frame_valid),
        .wr_data  (frame_data),
        .full     (full),
        .rd_valid (head_valid),
        .rd_data  (head_data),
        .rd_pop   (head_pop)
    );

    // scale by gain, then hold results for the receiver
    gfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_pop   (head_pop),
        .rate_gain  (rate_gain_reg),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign rate_raw    = $signed(result.rate_raw);
    assign rate_scaled = $signed(result.rate_scaled);
    assign temperature = result.temperature;
    assign rate_ok     = result.rate_ok;
    assign temp_ok     = result.temp_ok;

endmodule

// File: src/gfd_front.sv
module gfd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic [7:0]      rx_byte,
    input  logic            frame_start,
    output logic            frame_valid,
    output gfd_pkg::frame_t frame_data
);

    logic [3:0]  byte_index_reg, byte_index_next;
    logic [7:0]  rate_xor_reg, rate_xor_next;
    logic [7:0]  temp_xor_reg, temp_xor_next;
    logic [31:0] rate_accum_reg, rate_accum_next;
    logic [13:0] temp_accum_reg, temp_accum_next;
    logic [7:0]  rate_check_reg, rate_check_next;
    logic [3:0]  idx;
    logic [7:0]  temp_xor_full;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        rate_xor_next   = rate_xor_reg;
        temp_xor_next   = temp_xor_reg;
        rate_accum_next = rate_accum_reg;
        temp_accum_next = temp_accum_reg;
        rate_check_next = rate_check_reg;
        frame_valid     = 1'b0;
        idx             = frame_start ? gfd_pkg::IDX_RATE_B0 : byte_index_reg;

        if (byte_valid && frame_start)
        begin
            rate_xor_next   = '0;
            temp_xor_next   = '0;
            rate_accum_next = '0;
            temp_accum_next = '0;
            rate_check_next = '0;
        end

        if (byte_valid)
        begin
            unique case (idx)
                gfd_pkg::IDX_RATE_B0:
                begin
                    rate_xor_next   = rx_byte;
                    rate_accum_next = {24'd0, rx_byte};
                    byte_index_next = gfd_pkg::IDX_RATE_B1;
                end
                gfd_pkg::IDX_RATE_B1:
                begin
                    rate_xor_next   = rate_xor_reg ^ rx_byte;
                    rate_accum_next = rate_accum_reg | {17'd0, rx_byte, 7'd0};
                    byte_index_next = gfd_pkg::IDX_RATE_B2;
                end
                gfd_pkg::IDX_RATE_B2:
                begin
                    rate_xor_next   = rate_xor_reg ^ rx_byte;
                    rate_accum_next = rate_accum_reg | {10'd0, rx_byte, 14'd0};
                    byte_index_next = gfd_pkg::IDX_RATE_B3;
                end
                gfd_pkg::IDX_RATE_B3:
                begin
                    rate_xor_next   = rate_xor_reg ^ rx_byte;
                    rate_accum_next = rate_accum_reg | {3'd0, rx_byte, 21'd0};
                    byte_index_next = gfd_pkg::IDX_RATE_B4;
                end
                gfd_pkg::IDX_RATE_B4:
                begin
                    // upper nibble falls off the 32-bit word
                    rate_xor_next   = rate_xor_reg ^ rx_byte;
                    rate_accum_next = rate_accum_reg | {rx_byte[3:0], 28'd0};
                    byte_index_next = gfd_pkg::IDX_RATE_CHECK;
                end
                gfd_pkg::IDX_RATE_CHECK:
                begin
                    rate_check_next = rx_byte;
                    byte_index_next = gfd_pkg::IDX_TEMP_LO;
                end
                gfd_pkg::IDX_TEMP_LO:
                begin
                    temp_xor_next   = temp_xor_reg ^ rx_byte;
                    temp_accum_next = temp_accum_reg | {6'd0, rx_byte};
                    byte_index_next = gfd_pkg::IDX_TEMP_HI;
                end
                gfd_pkg::IDX_TEMP_HI:
                begin
                    temp_xor_next   = temp_xor_reg ^ rx_byte;
                    temp_accum_next = temp_accum_reg | {rx_byte[6:0], 7'd0};
                    byte_index_next = gfd_pkg::IDX_TEMP_CHECK;
                end
                gfd_pkg::IDX_TEMP_CHECK:
                begin
                    frame_valid     = 1'b1;
                    byte_index_next = gfd_pkg::IDX_IDLE;
                end
                default:
                begin
                    // idle: stray bytes dropped
                    byte_index_next = byte_index_reg;
                end
            endcase
        end
    end

    assign temp_xor_full = temp_xor_reg & gfd_pkg::CHECK_MASK;

    always_comb
    begin
        frame_data.rate_raw    = rate_accum_reg;
        frame_data.temperature = temp_accum_reg;
        frame_data.rate_ok     = ((rate_xor_reg & gfd_pkg::CHECK_MASK) == rate_check_reg);
        frame_data.temp_ok     = (temp_xor_full == rx_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= gfd_pkg::IDX_IDLE;
            rate_xor_reg   <= '0;
            temp_xor_reg   <= '0;
            rate_accum_reg <= '0;
            temp_accum_reg <= '0;
            rate_check_reg <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            rate_xor_reg   <= rate_xor_next;
            temp_xor_reg   <= temp_xor_next;
            rate_accum_reg <= rate_accum_next;
            temp_accum_reg <= temp_accum_next;
            rate_check_reg <= rate_check_next;
        end
    end

endmodule

// File: src/gfd_queue.sv
module gfd_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    input  gfd_pkg::frame_t wr_data,
    output logic            full,
    output logic            rd_valid,
    output gfd_pkg::frame_t rd_data,
    input  logic            rd_pop
);

    gfd_pkg::frame_t                mem_reg [gfd_pkg::QUEUE_DEPTH];
    logic [gfd_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [gfd_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [gfd_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign full     = (count_reg == gfd_pkg::CNT_W'(gfd_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + gfd_pkg::CNT_W'(do_wr) - gfd_pkg::CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/gfd_back.sv
module gfd_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  gfd_pkg::frame_t  head_data,
    output logic             head_pop,
    input  logic [23:0]      rate_gain,
    output logic             empty,
    input  logic             pop,
    output gfd_pkg::result_t result
);

    logic                      mul_valid_reg, mul_valid_next;
    gfd_pkg::frame_t           mul_frame_reg;
    logic [39:0]               mul_scaled_reg;
    logic signed [56:0]        product;

    gfd_pkg::result_t          out_mem_reg [gfd_pkg::QUEUE_DEPTH];
    logic [gfd_pkg::PTR_W-1:0] out_wr_ptr_reg, out_wr_ptr_next;
    logic [gfd_pkg::PTR_W-1:0] out_rd_ptr_reg, out_rd_ptr_next;
    logic [gfd_pkg::CNT_W-1:0] out_count_reg, out_count_next;
    logic [gfd_pkg::CNT_W-1:0] committed;
    logic                      do_pop;
    gfd_pkg::result_t          mul_result;

    // take a new frame only if the output queue is sure to have room for it
    assign committed = out_count_reg + gfd_pkg::CNT_W'(mul_valid_reg);
    assign head_pop  = head_valid && (committed < gfd_pkg::CNT_W'(gfd_pkg::QUEUE_DEPTH));
    assign product   = $signed(head_data.rate_raw) * $signed({1'b0, rate_gain});

    assign empty  = (out_count_reg == '0);
    assign do_pop = pop && !empty;
    assign result = out_mem_reg[out_rd_ptr_reg];

    always_comb
    begin
        mul_result.rate_raw    = mul_frame_reg.rate_raw;
        mul_result.rate_scaled = mul_scaled_reg;
        mul_result.temperature = mul_frame_reg.temperature;
        mul_result.rate_ok     = mul_frame_reg.rate_ok;
        mul_result.temp_ok     = mul_frame_reg.temp_ok;
    end

    always_comb
    begin
        mul_valid_next  = head_pop;
        out_wr_ptr_next = mul_valid_reg ? out_wr_ptr_reg + 1'b1 : out_wr_ptr_reg;
        out_rd_ptr_next = do_pop ? out_rd_ptr_reg + 1'b1 : out_rd_ptr_reg;
        out_count_next  = out_count_reg + gfd_pkg::CNT_W'(mul_valid_reg)
                          - gfd_pkg::CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg  <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            mul_valid_reg  <= mul_valid_next;
            out_wr_ptr_reg <= out_wr_ptr_next;
            out_rd_ptr_reg <= out_rd_ptr_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            mul_frame_reg  <= head_data;
            mul_scaled_reg <= product[55:16];
        end
        if (mul_valid_reg)
        begin
            out_mem_reg[out_wr_ptr_reg] <= mul_result;
        end
    end

endmodule

// File: src/gfd_checker.sv
module gfd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] rate_raw,
    input logic signed [39:0] rate_scaled
);

    // result queue comes out of reset empty, input queue not full
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge clk) $rose(rst_n) |-> !full)
        else $error("input full after reset");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rate_raw) && $stable(rate_scaled)))
        else $error("waiting result changed without pop");

    // unsigned gain cannot turn a non-negative rate negative
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rate_raw[31]) |-> !rate_scaled[39])
        else $error("scaled rate sign does not follow raw rate");

endmodule

bind gyro_frame_decoder gfd_checker u_gfd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .rate_raw    (rate_raw),
    .rate_scaled (rate_scaled)
);
